FILE: design/ribpw_pkg.sv
// ----------------------------------------------------------------------------
// Raw image pixel writer package
// Shared types and constants for the image record pixel writer.
// ----------------------------------------------------------------------------
package ribpw_pkg;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 11;
    localparam int ORG_W   = 10;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEIGHT = 3'b010,
        PH_PIXELS = 3'b100
    } t_phase;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ENA = 2'd2;

    localparam logic [1:0] TRIPLE_RED   = 2'd0;
    localparam logic [1:0] TRIPLE_BLUE  = 2'd1;
    localparam logic [1:0] TRIPLE_GREEN = 2'd2;

    typedef struct packed {
        t_cmd               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic               done;
    } t_result;

endpackage

FILE: design/raw_image_byte_to_pixel_writer.sv
// ----------------------------------------------------------------------------
// Raw image byte to pixel writer
// Turns the byte stream of a stored image record into pixel write commands.
// ----------------------------------------------------------------------------
// Usage: bytes of an image record arrive on the input channel (i_in_valid,
// o_in_stall), the width byte flagged by i_record_start, then the height byte,
// then colour triples in the order red, blue, green. Every third colour byte
// produces one pixel write on the output channel (o_out_valid, i_out_stall).
// In centre mode a clear-screen command is sent when the height byte arrives.
// One byte is taken per clock cycle while o_in_stall is low. The byte update
// is a single pass of counter and adder logic into the output register, or
// into the skid register while the output stalls. Together they allow one
// result to wait while the next byte is taken; o_in_stall rises only when both
// hold a result and the receiver stalls. The configuration port is always
// ready; the user must write it only while idle, which the block does not
// enforce. Reset clears the channel valids, the record state and the
// configuration registers; the block is then idle and waits for a record start.
// ----------------------------------------------------------------------------
module raw_image_byte_to_pixel_writer #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ribpw_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                           i_record_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_command_kind,
    output logic [ribpw_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [ribpw_pkg::COORD_W-1:0]  o_pixel_y,
    output logic [ribpw_pkg::BYTE_W-1:0]   o_red,
    output logic [ribpw_pkg::BYTE_W-1:0]   o_green,
    output logic [ribpw_pkg::BYTE_W-1:0]   o_blue,
    output logic                           o_image_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ribpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ribpw_pkg::ORG_W-1:0]    i_cfg_data
);
    import ribpw_pkg::*;

    localparam logic [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_W);
    localparam logic [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_H);

    logic [ORG_W-1:0]   r_origin_x;
    logic [ORG_W-1:0]   r_origin_y;
    logic               r_center;

    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_width, n_width;
    logic [BYTE_W-1:0]  r_height, n_height;
    logic [1:0]         r_triple, n_triple;
    logic [BYTE_W-1:0]  r_held_red, n_held_red;
    logic [BYTE_W-1:0]  r_held_blue, n_held_blue;
    logic [BYTE_W-1:0]  r_column, n_column;
    logic [BYTE_W-1:0]  r_row, n_row;
    logic [COORD_W-1:0] r_base_x, n_base_x;
    logic [COORD_W-1:0] r_base_y, n_base_y;

    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               in_fire;
    logic               out_free;
    logic               res_valid;
    t_result            res;
    logic [BYTE_W-1:0]  col_inc;
    logic [BYTE_W-1:0]  row_inc;
    logic [COORD_W-1:0] cen_x;
    logic [COORD_W-1:0] cen_y;

    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    assign col_inc = r_column + 1'b1;
    assign row_inc = r_row + 1'b1;
    assign cen_x = ({3'b000, r_width} >= SCR_W) ? '0
                 : COORD_W'((SCR_W - {3'b000, r_width}) >> 1);
    assign cen_y = ({3'b000, i_data_byte} >= SCR_H) ? '0
                 : COORD_W'((SCR_H - {3'b000, i_data_byte}) >> 1);

    always_comb begin
        n_phase     = r_phase;
        n_width     = r_width;
        n_height    = r_height;
        n_triple    = r_triple;
        n_held_red  = r_held_red;
        n_held_blue = r_held_blue;
        n_column    = r_column;
        n_row       = r_row;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = CMD_PIXEL;
        if (in_fire) begin
            if (i_record_start) begin
                n_width  = i_data_byte;
                n_triple = TRIPLE_RED;
                n_column = '0;
                n_row    = '0;
                n_phase  = PH_HEIGHT;
            end else begin
                case (r_phase)
                    PH_HEIGHT: begin
                        n_height = i_data_byte;
                        n_triple = TRIPLE_RED;
                        n_column = '0;
                        n_row    = '0;
                        if (r_center) begin
                            n_base_x  = cen_x;
                            n_base_y  = cen_y;
                            res_valid = 1'b1;
                            res.kind  = CMD_CLEAR;
                        end else begin
                            n_base_x = {1'b0, r_origin_x};
                            n_base_y = {1'b0, r_origin_y};
                        end
                        if (r_width == '0 || i_data_byte == '0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_PIXELS;
                        end
                    end
                    PH_PIXELS: begin
                        case (r_triple)
                            TRIPLE_RED: begin
                                n_held_red = i_data_byte;
                                n_triple   = TRIPLE_BLUE;
                            end
                            TRIPLE_BLUE: begin
                                n_held_blue = i_data_byte;
                                n_triple    = TRIPLE_GREEN;
                            end
                            default: begin
                                n_triple  = TRIPLE_RED;
                                res_valid = 1'b1;
                                res.x     = r_base_x + {3'b000, r_column};
                                res.y     = r_base_y + {3'b000, r_row};
                                res.red   = r_held_red;
                                res.green = i_data_byte;
                                res.blue  = r_held_blue;
                                if (col_inc >= r_width) begin
                                    n_column = '0;
                                    n_row    = row_inc;
                                    if (row_inc >= r_height) begin
                                        res.done = 1'b1;
                                        n_phase  = PH_IDLE;
                                    end
                                end else begin
                                    n_column = col_inc;
                                end
                            end
                        endcase
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_center   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ORIGIN_X:   r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y:   r_origin_y <= i_cfg_data;
                REG_CENTER_ENA: r_center   <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_triple    <= TRIPLE_RED;
            r_width     <= '0;
            r_height    <= '0;
            r_held_red  <= '0;
            r_held_blue <= '0;
            r_column    <= '0;
            r_row       <= '0;
            r_base_x    <= '0;
            r_base_y    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_triple    <= n_triple;
            r_width     <= n_width;
            r_height    <= n_height;
            r_held_red  <= n_held_red;
            r_held_blue <= n_held_blue;
            r_column    <= n_column;
            r_row       <= n_row;
            r_base_x    <= n_base_x;
            r_base_y    <= n_base_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command_kind = r_out.kind;
    assign o_pixel_x      = r_out.x;
    assign o_pixel_y      = r_out.y;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_image_done   = r_out.done;

endmodule

FILE: design/ribpw_checker.sv
// ----------------------------------------------------------------------------
// Raw image pixel writer checker
// Port-level assertions for the image record pixel writer, bound to the top.
// ----------------------------------------------------------------------------
module ribpw_assertions (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [ribpw_pkg::BYTE_W-1:0]    i_data_byte,
    input logic                            i_record_start,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_command_kind,
    input logic [ribpw_pkg::COORD_W-1:0]   o_pixel_x,
    input logic [ribpw_pkg::COORD_W-1:0]   o_pixel_y,
    input logic [ribpw_pkg::BYTE_W-1:0]    o_red,
    input logic [ribpw_pkg::BYTE_W-1:0]    o_green,
    input logic [ribpw_pkg::BYTE_W-1:0]    o_blue,
    input logic                            o_image_done,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [ribpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [ribpw_pkg::ORG_W-1:0]     i_cfg_data
);
    import ribpw_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output valid dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_command_kind))
        else $error("Output payload changed while stalled.");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_kind == CMD_CLEAR |->
            o_pixel_x == '0 && o_pixel_y == '0 && o_red == '0
            && o_green == '0 && o_blue == '0 && !o_image_done)
        else $error("Clear command carries nonzero fields.");

    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> o_out_valid && $past(o_out_valid && i_out_stall))
        else $error("Input stalled without a waiting result.");

endmodule

bind raw_image_byte_to_pixel_writer ribpw_assertions u_ribpw_assertions (.*);
